### src/mapt_pkg.sv
// ----------------------------------------------------------------------------
// mapt_pkg
// Shared types and constants for the MAP-T IPv4 ingress classifier.
// ----------------------------------------------------------------------------
package mapt_pkg;

  // Next-hop classes
  localparam logic [2:0] CLS_TCP_UDP  = 3'd0;
  localparam logic [2:0] CLS_ICMP     = 3'd1;
  localparam logic [2:0] CLS_FRAG     = 3'd2;
  localparam logic [2:0] CLS_ICMP_ERR = 3'd3;
  localparam logic [2:0] CLS_DROP     = 3'd4;
  localparam logic [2:0] CLS_PASS     = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_MALFORMED = 3'd2;
  localparam logic [2:0] ERR_BAD_PROTO = 3'd3;
  localparam logic [2:0] ERR_SEC       = 3'd4;
  localparam logic [2:0] ERR_TTL       = 3'd5;
  localparam logic [2:0] ERR_DF        = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_ONE_TO_ONE  = 3'd0;
  localparam logic [2:0] REG_DOMAIN_MTU  = 3'd1;
  localparam logic [2:0] REG_PSID_BITS   = 3'd2;
  localparam logic [2:0] REG_PSID_SHIFT  = 3'd3;
  localparam logic [2:0] REG_IGNORE_DF   = 3'd4;

  // Header constants
  localparam logic [7:0]  VERSION_IHL_OK = 8'h45;
  localparam logic [7:0]  TTL_EXPIRING   = 8'd1;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [15:0] TCP_MIN_LEN    = 16'd40;
  localparam logic [15:0] UDP_MIN_LEN    = 16'd28;
  localparam logic [5:0]  TCP_CSUM_OFF   = 6'd36;
  localparam logic [5:0]  UDP_CSUM_OFF   = 6'd26;
  localparam logic [15:0] IPV4_HDR_LEN   = 16'd20;
  localparam logic [15:0] NO_PORT        = 16'hFFFF;
  localparam logic [15:0] MTU_UNLIMITED  = 16'hFFFF;
  localparam logic [4:0]  PORT_BITS      = 5'd16;

  typedef struct packed {
    logic        one_to_one_mode;
    logic [15:0] domain_mtu;
    logic [4:0]  psid_bits;
    logic [4:0]  psid_shift;
    logic        ignore_df;
  } cfg_t;

  typedef struct packed {
    logic [15:0] buffer_length;
    logic [15:0] total_length;
    logic [7:0]  version_ihl;
    logic [7:0]  hop_ttl;
    logic [7:0]  proto_number;
    logic        dont_fragment;
    logic [12:0] fragment_offset;
    logic [15:0] l4_port;
    logic [7:0]  icmp_type_byte;
    logic        domain_hit;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  next_hop_class;
    logic [2:0]  error_code;
    logic [15:0] mapping_port;
    logic [5:0]  csum_offset;
    logic [15:0] effective_mtu;
    logic [15:0] icmp_reply_mtu;
    logic        count_tx;
  } res_t;

endpackage

### src/mapt_classify.sv
// ----------------------------------------------------------------------------
// mapt_classify
// Decision logic for one IPv4 header summary: sanity, domain, TTL, DF, protocol
// sort with minimum lengths and the PSID well-known port check.
// ----------------------------------------------------------------------------
module mapt_classify
  import mapt_pkg::*;
(
  input  cfg_t cfg,
  input  hdr_t hdr,
  output res_t res
);

  logic [15:0] eff_mtu;
  logic [16:0] len_plus_hdr;
  logic        hdr_bad;
  logic        df_fail;
  logic [4:0]  bound_shift;
  logic [16:0] port_bound;
  logic        psid_on;
  logic [2:0]  cls;
  logic [2:0]  err;
  logic [15:0] port;

  // Unlimited MTU reads as the largest value
  assign eff_mtu      = (cfg.domain_mtu != 16'd0) ? cfg.domain_mtu : MTU_UNLIMITED;
  assign len_plus_hdr = {1'b0, hdr.total_length} + {1'b0, IPV4_HDR_LEN};
  assign hdr_bad      = (hdr.buffer_length < hdr.total_length) ||
                        (hdr.version_ihl != VERSION_IHL_OK);
  assign df_fail      = hdr.dont_fragment && !cfg.ignore_df &&
                        (len_plus_hdr > {1'b0, eff_mtu});

  // Well-known port bound is 1 << (16 - offset), floor of 1
  assign bound_shift  = (cfg.psid_shift >= PORT_BITS) ? 5'd0 : PORT_BITS - cfg.psid_shift;
  assign port_bound   = 17'd1 << bound_shift;
  assign psid_on      = (cfg.psid_bits != 5'd0) && (cfg.psid_shift != 5'd0);

  // Sort the packet in check order
  always_comb begin
    cls = CLS_PASS;
    err = ERR_NONE;
    port = NO_PORT;
    res = '0;
    res.effective_mtu = eff_mtu;
    res.csum_offset = 6'd0;
    res.icmp_reply_mtu = 16'd0;
    res.count_tx = 1'b0;
    if (hdr.domain_hit) begin
      if (hdr_bad) begin
        err = ERR_UNKNOWN;
      end
      if (hdr.hop_ttl == TTL_EXPIRING) begin
        cls = CLS_ICMP_ERR;
        err = ERR_TTL;
      end else if (df_fail) begin
        cls = CLS_ICMP_ERR;
        err = ERR_DF;
        res.icmp_reply_mtu = eff_mtu - IPV4_HDR_LEN;
      end else begin
        if (hdr.fragment_offset != 13'd0) begin
          cls = CLS_FRAG;
          port = cfg.one_to_one_mode ? 16'd0 : hdr.l4_port;
        end else if (hdr.proto_number == PROTO_TCP) begin
          cls = CLS_TCP_UDP;
          res.csum_offset = TCP_CSUM_OFF;
          if (hdr.total_length < TCP_MIN_LEN) begin
            err = ERR_MALFORMED;
          end
          port = hdr.l4_port;
        end else if (hdr.proto_number == PROTO_UDP) begin
          cls = CLS_TCP_UDP;
          res.csum_offset = UDP_CSUM_OFF;
          if (hdr.total_length < UDP_MIN_LEN) begin
            err = ERR_MALFORMED;
          end
          port = hdr.l4_port;
        end else if (hdr.proto_number == PROTO_ICMP) begin
          cls = CLS_ICMP;
          if (cfg.one_to_one_mode) begin
            port = 16'd0;
          end else if (hdr.icmp_type_byte == ICMP_ECHO_REPLY ||
                       hdr.icmp_type_byte == ICMP_ECHO_REQUEST) begin
            port = hdr.l4_port;
          end
        end else begin
          cls = CLS_TCP_UDP;
          err = ERR_BAD_PROTO;
        end

        // Reject well-known ports
        if (psid_on && ({1'b0, port} < port_bound)) begin
          err = ERR_SEC;
        end

        res.count_tx = (err == ERR_NONE) && (cls != CLS_ICMP);
        if (err != ERR_NONE) begin
          cls = CLS_DROP;
        end
      end
    end
    res.next_hop_class = cls;
    res.error_code = err;
    res.mapping_port = port;
  end

endmodule

### src/mapt_ipv4_ingress_classifier_unit.sv
// ----------------------------------------------------------------------------
// mapt_ipv4_ingress_classifier_unit
// MAP-T IPv4 ingress classifier: one header summary in, one decision out.
// ----------------------------------------------------------------------------
// Path: input register, decision logic, result register.
// Throughput: one item per cycle; both stages advance whenever the result
//   register is empty or being taken.
// Reset: clears both stage valid flags and all configuration registers to 0.
module mapt_ipv4_ingress_classifier_unit
  import mapt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: buffer_length[15:0], total_length[31:16],
  // version_ihl[39:32], hop_ttl[47:40], proto_number[55:48],
  // dont_fragment[56], fragment_offset[69:57], l4_port[85:70],
  // icmp_type_byte[93:86], domain_hit[94], zero[95]
  input  logic [95:0] s_tdata,
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: next_hop_class[2:0], error_code[5:3],
  // mapping_port[21:6], csum_offset[27:22], effective_mtu[43:28],
  // icmp_reply_mtu[59:44], count_tx[60], zero[63:61]
  output logic [63:0] m_tdata,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  hdr_t hdr;
  logic in_valid;
  res_t res_next;
  res_t res;
  logic out_valid;
  logic advance;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ONE_TO_ONE:  cfg.one_to_one_mode <= cfg_data[0];
        REG_DOMAIN_MTU:  cfg.domain_mtu <= cfg_data;
        REG_PSID_BITS:   cfg.psid_bits <= cfg_data[4:0];
        REG_PSID_SHIFT:  cfg.psid_shift <= cfg_data[4:0];
        REG_IGNORE_DF:   cfg.ignore_df <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hdr.buffer_length   <= s_tdata[15:0];
      hdr.total_length    <= s_tdata[31:16];
      hdr.version_ihl     <= s_tdata[39:32];
      hdr.hop_ttl         <= s_tdata[47:40];
      hdr.proto_number    <= s_tdata[55:48];
      hdr.dont_fragment   <= s_tdata[56];
      hdr.fragment_offset <= s_tdata[69:57];
      hdr.l4_port         <= s_tdata[85:70];
      hdr.icmp_type_byte  <= s_tdata[93:86];
      hdr.domain_hit      <= s_tdata[94];
    end
  end

  // Decision logic
  mapt_classify u_classify (
    .cfg (cfg),
    .hdr (hdr),
    .res (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, res.count_tx, res.icmp_reply_mtu, res.effective_mtu,
                     res.csum_offset, res.mapping_port, res.error_code,
                     res.next_hop_class};

  // Checks
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid))
    else $error("pipeline not empty after reset");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are held");

  a_tx_no_error: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.count_tx) |-> (res.error_code == ERR_NONE &&
                                    res.next_hop_class != CLS_ICMP))
    else $error("count_tx set on an errored or ICMP item");

  a_drop_has_error: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.next_hop_class == CLS_DROP) |-> (res.error_code != ERR_NONE))
    else $error("dropped item without an error code");

  a_reply_mtu_df: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.icmp_reply_mtu != 16'd0) |-> (res.error_code == ERR_DF))
    else $error("reply MTU reported without a DF error");

endmodule

### tb/sv/mapt_ipv4_ingress_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapt_ipv4_ingress_classifier_unit_tb
// Drives IPv4 header summaries into the classifier under several register
// settings. A scoreboard predicts each routing decision and checks every
// result item field by field, in order. Input bursts and result stalls
// are random.
// ----------------------------------------------------------------------------
module mapt_ipv4_ingress_classifier_unit_tb
  import mapt_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  // Predicts routing decisions and checks them in arrival order
  class route_checker;
    cfg_t        regs;
    res_t        expected_routes[$];
    int unsigned mismatches;

    function new();
      regs       = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_ONE_TO_ONE:  regs.one_to_one_mode = data[0];
        REG_DOMAIN_MTU:  regs.domain_mtu      = data;
        REG_PSID_BITS:   regs.psid_bits       = data[4:0];
        REG_PSID_SHIFT:  regs.psid_shift      = data[4:0];
        REG_IGNORE_DF:   regs.ignore_df       = data[0];
        default: ;
      endcase
    endfunction

    // Work out where one header goes under the current registers
    function res_t decide_route(hdr_t h);
      res_t        r;
      int unsigned eff;
      int unsigned shift;
      eff              = (regs.domain_mtu == 16'd0) ? 32'(MTU_UNLIMITED) : 32'(regs.domain_mtu);
      r.next_hop_class = CLS_PASS;
      r.error_code     = ERR_NONE;
      r.mapping_port   = NO_PORT;
      r.csum_offset    = '0;
      r.effective_mtu  = eff[15:0];
      r.icmp_reply_mtu = '0;
      r.count_tx       = 1'b0;
      if (h.domain_hit) begin
        // header sanity: kept unless a later check replaces it
        if (h.buffer_length < h.total_length || h.version_ihl != VERSION_IHL_OK) begin
          r.error_code = ERR_UNKNOWN;
        end
        if (h.hop_ttl == TTL_EXPIRING) begin
          r.next_hop_class = CLS_ICMP_ERR;
          r.error_code     = ERR_TTL;
        end else if (h.dont_fragment && !regs.ignore_df &&
                     32'(h.total_length) + 32'(IPV4_HDR_LEN) > eff) begin
          r.next_hop_class = CLS_ICMP_ERR;
          r.error_code     = ERR_DF;
          r.icmp_reply_mtu = 16'(eff - 32'(IPV4_HDR_LEN));
        end else begin
          // sort by fragment and protocol
          if (h.fragment_offset != 13'd0) begin
            r.next_hop_class = CLS_FRAG;
            r.mapping_port   = regs.one_to_one_mode ? 16'd0 : h.l4_port;
          end else if (h.proto_number == PROTO_TCP) begin
            r.next_hop_class = CLS_TCP_UDP;
            r.csum_offset    = TCP_CSUM_OFF;
            r.mapping_port   = h.l4_port;
            if (h.total_length < TCP_MIN_LEN) r.error_code = ERR_MALFORMED;
          end else if (h.proto_number == PROTO_UDP) begin
            r.next_hop_class = CLS_TCP_UDP;
            r.csum_offset    = UDP_CSUM_OFF;
            r.mapping_port   = h.l4_port;
            if (h.total_length < UDP_MIN_LEN) r.error_code = ERR_MALFORMED;
          end else if (h.proto_number == PROTO_ICMP) begin
            r.next_hop_class = CLS_ICMP;
            if (regs.one_to_one_mode) begin
              r.mapping_port = 16'd0;
            end else if (h.icmp_type_byte == ICMP_ECHO_REPLY ||
                         h.icmp_type_byte == ICMP_ECHO_REQUEST) begin
              r.mapping_port = h.l4_port;
            end
          end else begin
            r.next_hop_class = CLS_TCP_UDP;
            r.error_code     = ERR_BAD_PROTO;
          end
          // reject ports below the well-known bound
          if (regs.psid_bits != 5'd0 && regs.psid_shift != 5'd0) begin
            shift = (regs.psid_shift >= PORT_BITS) ? 0 : 16 - 32'(regs.psid_shift);
            if (32'(r.mapping_port) < (32'd1 << shift)) r.error_code = ERR_SEC;
          end
          r.count_tx = (r.error_code == ERR_NONE && r.next_hop_class != CLS_ICMP);
          if (r.error_code != ERR_NONE) r.next_hop_class = CLS_DROP;
        end
      end
      return r;
    endfunction

    function void note_header(logic [95:0] d);
      hdr_t h;
      h.buffer_length   = d[15:0];
      h.total_length    = d[31:16];
      h.version_ihl     = d[39:32];
      h.hop_ttl         = d[47:40];
      h.proto_number    = d[55:48];
      h.dont_fragment   = d[56];
      h.fragment_offset = d[69:57];
      h.l4_port         = d[85:70];
      h.icmp_type_byte  = d[93:86];
      h.domain_hit      = d[94];
      expected_routes.push_back(decide_route(h));
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_route(logic [63:0] d);
      res_t want;
      if (expected_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with none pending: %h", d);
        return;
      end
      want = expected_routes.pop_front();
      if (d[2:0] !== want.next_hop_class) flag("next_hop_class", 16'(want.next_hop_class), 16'(d[2:0]));
      if (d[5:3] !== want.error_code) flag("error_code", 16'(want.error_code), 16'(d[5:3]));
      if (d[21:6] !== want.mapping_port) flag("mapping_port", want.mapping_port, d[21:6]);
      if (d[27:22] !== want.csum_offset) flag("csum_offset", 16'(want.csum_offset), 16'(d[27:22]));
      if (d[43:28] !== want.effective_mtu) flag("effective_mtu", want.effective_mtu, d[43:28]);
      if (d[59:44] !== want.icmp_reply_mtu) flag("icmp_reply_mtu", want.icmp_reply_mtu, d[59:44]);
      if (d[60] !== want.count_tx) flag("count_tx", 16'(want.count_tx), 16'(d[60]));
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  route_checker board;
  int unsigned  idle_cycles;
  logic [1:0]   stall_mode = '0;
  int unsigned  stall_left = 0;

  mapt_ipv4_ingress_classifier_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result-side backpressure: switch between stall patterns every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_left[3:0] < 4'd3);
    endcase
  end

  // Observe every handshake; end the run if the block stops moving
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) board.note_header(s_tdata);
      if (m_tvalid && m_tready) board.check_route(m_tdata);
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("mapt_ipv4_ingress_classifier_unit_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one item and hold it until taken; valid stays high
  task automatic send_header(input hdr_t h);
    s_tdata  <= {1'b0, h.domain_hit, h.icmp_type_byte, h.l4_port, h.fragment_offset,
                 h.dont_fragment, h.proto_number, h.hop_ttl, h.version_ihl,
                 h.total_length, h.buffer_length};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every decision has come back; the first edge
  // lets the monitor note the last item taken
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(REG_ONE_TO_ONE, {15'd0, c.one_to_one_mode});
    write_reg(REG_DOMAIN_MTU, c.domain_mtu);
    write_reg(REG_PSID_BITS, {11'd0, c.psid_bits});
    write_reg(REG_PSID_SHIFT, {11'd0, c.psid_shift});
    write_reg(REG_IGNORE_DF, {15'd0, c.ignore_df});
    cfg_valid <= 1'b0;
  endtask

  function automatic hdr_t good_header(logic [7:0] proto, logic [15:0] port,
                                       logic [15:0] len);
    hdr_t h;
    h.buffer_length   = len;
    h.total_length    = len;
    h.version_ihl     = VERSION_IHL_OK;
    h.hop_ttl         = 8'd64;
    h.proto_number    = proto;
    h.dont_fragment   = 1'b0;
    h.fragment_offset = '0;
    h.l4_port         = port;
    h.icmp_type_byte  = ICMP_ECHO_REQUEST;
    h.domain_hit      = 1'b1;
    return h;
  endfunction

  // Mostly sane headers for a domain hit, with some header damage and noise
  function automatic hdr_t make_header();
    hdr_t        h;
    logic [95:0] raw;
    int unsigned shift;
    raw = {$urandom, $urandom, $urandom};
    h   = raw[94:0];
    if ($urandom_range(0, 99) < 80) begin
      h.domain_hit  = 1'b1;
      h.version_ihl = VERSION_IHL_OK;
      if (h.hop_ttl == TTL_EXPIRING) h.hop_ttl = 8'd0;
      case ($urandom_range(0, 3))
        0:       h.total_length = 16'($urandom_range(0, 60));
        1:       h.total_length = 16'($urandom_range(1200, 1520));
        2:       h.total_length = board.regs.domain_mtu - 16'($urandom_range(18, 22));
        default: ;
      endcase
      h.buffer_length = h.total_length + 16'($urandom_range(0, 8));
      if (h.buffer_length < h.total_length) h.buffer_length = h.total_length;
      case ($urandom_range(0, 3))
        0:       h.proto_number = PROTO_TCP;
        1:       h.proto_number = PROTO_UDP;
        2:       h.proto_number = PROTO_ICMP;
        default: ;
      endcase
      if ($urandom_range(0, 99) < 85) h.fragment_offset = '0;
      case ($urandom_range(0, 2))
        0:       h.icmp_type_byte = ICMP_ECHO_REPLY;
        1:       h.icmp_type_byte = ICMP_ECHO_REQUEST;
        default: ;
      endcase
      // ports around the well-known bound
      shift = (board.regs.psid_shift == 5'd0 || board.regs.psid_shift >= PORT_BITS) ?
              0 : 16 - 32'(board.regs.psid_shift);
      case ($urandom_range(0, 3))
        0:       h.l4_port = 16'($urandom_range(0, 63));
        1:       h.l4_port = 16'((32'd1 << shift) - $urandom_range(0, 1));
        default: ;
      endcase
      // damaged headers
      if ($urandom_range(0, 9) == 0 && h.total_length != 16'd0) begin
        h.buffer_length = h.total_length - 16'd1;
      end
      if ($urandom_range(0, 19) == 0) h.version_ihl = 8'h46;
    end else begin
      if ($urandom_range(0, 3) == 0) h.hop_ttl = TTL_EXPIRING;
      if ($urandom_range(0, 3) == 0) h.version_ihl = VERSION_IHL_OK;
    end
    return h;
  endfunction

  // Bursts of random length with random gaps, sometimes none
  task automatic send_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_header(make_header());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  task automatic send_directed();
    hdr_t h;
    set_config(cfg_t'{1'b0, 16'd1280, 5'd6, 5'd6, 1'b0});
    // plain TCP, UDP at its minimum, both just under their minimum
    send_header(good_header(PROTO_TCP, 16'd8000, 16'd60));
    send_header(good_header(PROTO_UDP, NO_PORT, UDP_MIN_LEN));
    send_header(good_header(PROTO_TCP, 16'd8000, TCP_MIN_LEN - 16'd1));
    send_header(good_header(PROTO_UDP, 16'd8000, UDP_MIN_LEN - 16'd1));
    // echo and non-echo ICMP, unknown protocol
    h = good_header(PROTO_ICMP, 16'd5000, 16'd84);
    h.icmp_type_byte = ICMP_ECHO_REPLY;
    send_header(h);
    h.icmp_type_byte = 8'd3;
    send_header(h);
    send_header(good_header(8'd47, 16'd8000, 16'd60));
    // last fragment offset with port zero
    h = good_header(PROTO_TCP, 16'd0, 16'd60);
    h.fragment_offset = 13'h1FFF;
    send_header(h);
    // TTL expiry overrides a header error; TTL zero passes
    h = good_header(PROTO_TCP, 16'd8000, 16'd60);
    h.hop_ttl     = TTL_EXPIRING;
    h.version_ihl = 8'h46;
    send_header(h);
    h.hop_ttl     = 8'd0;
    h.version_ihl = VERSION_IHL_OK;
    send_header(h);
    // DF just over and just within the domain MTU
    h = good_header(PROTO_UDP, 16'd8000, 16'd1261);
    h.dont_fragment = 1'b1;
    send_header(h);
    h.total_length  = 16'd1260;
    h.buffer_length = 16'd1260;
    send_header(h);
    // header error kept, short buffer, domain miss hides a header error
    h = good_header(PROTO_TCP, 16'd8000, 16'd60);
    h.version_ihl = 8'h46;
    send_header(h);
    h.version_ihl   = VERSION_IHL_OK;
    h.buffer_length = 16'd59;
    send_header(h);
    h.domain_hit  = 1'b0;
    h.version_ihl = 8'h00;
    send_header(h);
    // either side of the well-known bound
    send_header(good_header(PROTO_TCP, 16'd1023, 16'd60));
    send_header(good_header(PROTO_TCP, 16'd1024, 16'd60));
    send_header('1);
    send_header('0);
    drain();
    // tiny MTU, 1:1 domain, largest PSID offset
    set_config(cfg_t'{1'b1, 16'd1, 5'd16, 5'd16, 1'b0});
    h = good_header(PROTO_TCP, 16'd0, 16'd0);
    h.dont_fragment = 1'b1;
    send_header(h);
    h.dont_fragment = 1'b0;
    send_header(h);
    h.proto_number = PROTO_ICMP;
    send_header(h);
    h.fragment_offset = 13'd1;
    h.l4_port         = NO_PORT;
    send_header(h);
    drain();
    // unlimited MTU with DF ignored
    set_config(cfg_t'{1'b0, 16'd0, 5'd0, 5'd0, 1'b1});
    h = good_header(PROTO_TCP, 16'd80, 16'hFFFF);
    h.dont_fragment = 1'b1;
    send_header(h);
    drain();
  endtask

  // Reset, directed items, then random phases under varied settings
  initial begin
    cfg_t c;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_directed();
    for (int p = 0; p < 6; p++) begin
      c = '0;
      if (p == 1) begin
        c = cfg_t'{1'b1, 16'hFFFF, 5'd16, 5'd16, 1'b1};
      end else if (p > 1) begin
        c.one_to_one_mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0:       c.domain_mtu = 16'd0;
          1:       c.domain_mtu = 16'($urandom_range(1, 40));
          2:       c.domain_mtu = 16'($urandom_range(1280, 1500));
          3:       c.domain_mtu = 16'($urandom);
          default: c.domain_mtu = 16'hFFFF;
        endcase
        c.psid_bits  = 5'($urandom_range(0, 16));
        c.psid_shift = 5'($urandom_range(0, 16));
        c.ignore_df  = ($urandom_range(0, 3) == 0);
      end
      set_config(c);
      send_random(75);
      drain();
    end
    if (board.mismatches == 0) begin
      $display("mapt_ipv4_ingress_classifier_unit_tb passed");
    end else begin
      $display("mapt_ipv4_ingress_classifier_unit_tb failed");
    end
    $finish;
  end

endmodule
